// ----- hw/rtl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg
// Shared constants, curve-mode codes, interpolation tables and divider types
// for the throttle response curve pipeline.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int TABLE_BITS = 8;
    localparam int WB         = 30;                  // table/log fraction bits
    localparam int FRW        = WB - TABLE_BITS;     // interpolation fraction bits
    localparam int TSIZE      = (1 << TABLE_BITS) + 1;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int ONE_W      = FRAC_BITS + 1;       // magnitude width, holds ONE
    localparam int PW         = $clog2(FRAC_BITS);   // msb position width
    localparam int CURVE_ONE  = 4096;                // 1.0 in Q4.12
    localparam int EW         = 17;                  // exponent 1 + |c| in Q4.12
    localparam int NEGW       = WB + PW + 1;         // -log2(b) in Q.30
    localparam int YW         = NEGW + EW - 12;
    localparam int TLW        = ONE_W + 31 - FRAC_BITS;
    localparam int ZW         = 16 + TLW - 12;
    localparam int KPW        = 16 + ONE_W;
    localparam int DW         = 32 + 20;             // divider operand width

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    typedef enum logic [1:0] {
        MODE_POWER  = 2'd0,
        MODE_EXP    = 2'd1,
        MODE_POLY   = 2'd2,
        MODE_LINEAR = 2'd3
    } mode_t;

    localparam logic [1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [1:0] REG_ACCEL      = 2'd1;
    localparam logic [1:0] REG_BRAKE      = 2'd2;

    typedef logic [31:0] rom_t [TSIZE];

    typedef struct packed {
        logic [DW-1:0]    num;
        logic [DW-1:0]    den;
        logic             use_div;
        logic             inv;      // result is ONE minus quotient
        logic [ONE_W-1:0] res;      // result when the divider is bypassed
        logic             neg;
    } div_in_t;

    typedef struct packed {
        logic [DW-1:0]    rem;
        logic [DW-1:0]    den;
        logic [ONE_W-1:0] q;
        logic             sat;
        logic             use_div;
        logic             inv;
        logic [ONE_W-1:0] res;
        logic             neg;
    } div_stage_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bit_v;
        x     = x_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int s = 0; s < 32; s++)
        begin
            if (x >= res + bit_v)
            begin
                x   = x - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // log2 of 1 + i/2^TABLE_BITS by repeated squaring
    function automatic rom_t build_log_rom();
        rom_t        t;
        logic [63:0] m;
        logic [63:0] y;
        for (int i = 0; i < TSIZE; i++)
        begin
            m = 64'((1 << TABLE_BITS) + i) << (WB - TABLE_BITS);
            y = '0;
            if (m >= (64'd2 << WB))
            begin
                t[i] = 32'(64'd1 << WB);
            end
            else
            begin
                for (int j = 0; j < WB; j++)
                begin
                    m = (m * m) >> WB;
                    y = y << 1;
                    if (m >= (64'd2 << WB))
                    begin
                        m = m >> 1;
                        y = y | 64'd1;
                    end
                end
                t[i] = y[31:0];
            end
        end
        return t;
    endfunction

    // 2^(i/2^TABLE_BITS) as a product of repeated square roots of two
    function automatic rom_t build_exp_rom();
        rom_t        t;
        logic [63:0] roots [TABLE_BITS+1];
        logic [63:0] v;
        roots[0] = 64'd2 << WB;
        for (int j = 1; j <= TABLE_BITS; j++)
        begin
            roots[j] = isqrt64(roots[j-1] << WB);
        end
        for (int i = 0; i < TSIZE; i++)
        begin
            v = 64'd1 << WB;
            if (i == (1 << TABLE_BITS))
            begin
                v = 64'd2 << WB;
            end
            else
            begin
                for (int j = 1; j <= TABLE_BITS; j++)
                begin
                    if (((i >> (TABLE_BITS - j)) & 1) != 0)
                    begin
                        v = (v * roots[j]) >> WB;
                    end
                end
            end
            t[i] = v[31:0];
        end
        return t;
    endfunction

    localparam rom_t LOG_ROM = build_log_rom();
    localparam rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- hw/rtl/trc_div.sv -----
// ----------------------------------------------------------------------------
// trc_div
// Pipelined restoring fraction divider: floor(num * ONE / den), one quotient
// bit per stage; sat flags num >= den or den zero, where the result is ONE.
// ----------------------------------------------------------------------------
module trc_div
    import trc_pkg::*;
(
    input  logic               clk,
    input  logic [FRAC_BITS:0] en,
    input  div_in_t            d_in,
    output div_stage_t         d_out
);

    div_stage_t st_reg [FRAC_BITS+1];
    div_stage_t setup_next;

    always_comb
    begin
        setup_next.rem     = d_in.num;
        setup_next.den     = d_in.den;
        setup_next.q       = '0;
        setup_next.sat     = (d_in.den == '0) || (d_in.num >= d_in.den);
        setup_next.use_div = d_in.use_div;
        setup_next.inv     = d_in.inv;
        setup_next.res     = d_in.res;
        setup_next.neg     = d_in.neg;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= setup_next;
        end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++)
    begin : g_bit
        div_stage_t    bit_next;
        logic [DW:0]   r2;
        logic          qbit;

        always_comb
        begin
            bit_next = st_reg[j-1];
            r2       = {st_reg[j-1].rem, 1'b0};
            qbit     = 1'b0;
            if (!st_reg[j-1].sat && (r2 >= (DW+1)'(st_reg[j-1].den)))
            begin
                r2   = r2 - (DW+1)'(st_reg[j-1].den);
                qbit = 1'b1;
            end
            bit_next.rem = r2[DW-1:0];
            bit_next.q   = {st_reg[j-1].q[ONE_W-2:0], qbit};
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                st_reg[j] <= bit_next;
            end
        end
    end

    assign d_out = st_reg[FRAC_BITS];

endmodule

// ----- hw/rtl/throttle_response_curve_top.sv -----
// ----------------------------------------------------------------------------
// throttle_response_curve_top
// Clamps a Q1.14 throttle sample and shapes its magnitude with a power,
// exponential, rational or linear curve; the result keeps the input sign.
// ----------------------------------------------------------------------------
//   channel   signals                          beat
//   input     in_valid / in_ready              throttle_in
//   output    out_valid / out_ready            throttle_out
//   config    cfg_we, cfg_index, cfg_data      one register write, no wait
//
// The pipeline has 9 log/exp stages, FRAC_BITS + 1 divider stages and one output
// register; one beat is accepted every cycle unless the pipeline is full and stalled.
// Reset clears the stage valid bits and restores the configuration registers.
// A stage holds while the one after it is full and stalled; empty stages keep
// filling, so bubbles collapse and nothing is lost or repeated.
module throttle_response_curve_top
    import trc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] throttle_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] throttle_out,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int NF = 9;
    localparam int NS = NF + FRAC_BITS + 2;
    localparam logic signed [15:0] ONE_S = 16'(ONE);

    typedef struct packed {
        logic             neg;
        logic             cneg;
        mode_t            mode;
        logic [15:0]      k;
        logic [EW-1:0]    e;
        logic [ONE_W-1:0] a;
        logic [ONE_W-1:0] bsel;
        logic [ONE_W-1:0] osel;
        logic             pw_zero;
        logic             pw_full;
        logic [PW-1:0]    p;
        logic [TABLE_BITS-1:0] l_idx;
        logic [FRW-1:0]   l_fr;
        logic [31:0]      l_lo;
        logic [31:0]      l_hi;
        logic [31:0]      lg;
        logic [NEGW-1:0]  negq;
        logic [YW-1:0]    y;
        logic             pw_big;
        logic [5:0]       pw_sh;
        logic [TLW-1:0]   tl;
        logic [KPW-1:0]   kp;
        logic [ZW-1:0]    zn;
        logic [ZW-1:0]    zd;
        logic [31:0]      en_lo;
        logic [31:0]      en_hi;
        logic [31:0]      ed_lo;
        logic [31:0]      ed_hi;
        logic [FRW-1:0]   en_fr;
        logic [FRW-1:0]   ed_fr;
        logic [4:0]       zi_n;
        logic [4:0]       zi_d;
        logic [31:0]      vn;
        logic [31:0]      vd;
        logic [DW-1:0]    numv;
        logic [DW-1:0]    denv;
        logic             lin;
    } pipe_t;

    mode_t       curve_mode_reg;
    logic [15:0] accel_curve_reg;
    logic [15:0] brake_curve_reg;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_in;
    logic [NS:0]   rdy;

    pipe_t s1_reg, s1_next, s2_reg, s2_next, s3_reg, s3_next, s4_reg, s4_next;
    pipe_t s5_reg, s5_next, s6_reg, s6_next, s7_reg, s7_next, s8_reg, s8_next;
    div_in_t    d_in_reg, d_in_next;
    div_stage_t d_out;
    logic signed [15:0] out_reg, out_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_mode_reg  <= MODE_LINEAR;
            accel_curve_reg <= '0;
            brake_curve_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CURVE_MODE: curve_mode_reg  <= mode_t'(cfg_data[1:0]);
                REG_ACCEL:      accel_curve_reg <= cfg_data;
                REG_BRAKE:      brake_curve_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // stage handshake: a stage loads when it is empty or its content moves on
    assign rdy[NS] = out_ready;
    for (genvar i = 0; i < NS; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    assign vld_in = {vld_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    assign in_ready     = rdy[0];
    assign out_valid    = vld_reg[NS-1];
    assign throttle_out = out_reg;

    // S1: clamp, magnitude, curve select
    always_comb
    begin
        logic signed [15:0] xc;
        logic [15:0]        craw;
        s1_next = '0;
        if (throttle_in > ONE_S)
            xc = ONE_S;
        else if (throttle_in < -ONE_S)
            xc = -ONE_S;
        else
            xc = throttle_in;
        s1_next.neg  = xc[15];
        s1_next.a    = xc[15] ? ONE_W'(-xc) : ONE_W'(xc);
        craw         = xc[15] ? brake_curve_reg : accel_curve_reg;
        s1_next.cneg = craw[15];
        s1_next.k    = craw[15] ? (~craw + 16'd1) : craw;
        s1_next.e    = EW'(CURVE_ONE) + EW'(s1_next.k);
        s1_next.mode = curve_mode_reg;
        s1_next.bsel = craw[15] ? s1_next.a : ONE_W'(ONE) - s1_next.a;
        s1_next.osel = craw[15] ? ONE_W'(ONE) - s1_next.a : s1_next.a;
    end

    // S2: normalize for log2, t * log2(e), k * other side
    always_comb
    begin
        logic [WB:0]         mn;
        logic [ONE_W+30:0]   tlp;
        s2_next         = s1_reg;
        s2_next.p       = '0;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            if (s1_reg.bsel[i])
                s2_next.p = PW'(i);
        end
        s2_next.pw_zero = (s1_reg.bsel == '0);
        s2_next.pw_full = s1_reg.bsel[FRAC_BITS];
        mn              = (WB+1)'(s1_reg.bsel) << (WB - int'(s2_next.p));
        s2_next.l_idx   = mn[WB-1 -: TABLE_BITS];
        s2_next.l_fr    = mn[FRW-1:0];
        tlp             = (ONE_W+31)'(s1_reg.bsel) * (ONE_W+31)'(LOG2E_Q30);
        s2_next.tl      = tlp[FRAC_BITS +: TLW];
        s2_next.kp      = KPW'(s1_reg.k) * KPW'(s1_reg.osel);
    end

    // S3: log table read, exponents, rational operands
    always_comb
    begin
        logic [16+TLW-1:0] znp;
        logic [46:0]       zdp;
        s3_next      = s2_reg;
        s3_next.l_lo = LOG_ROM[{1'b0, s2_reg.l_idx}];
        s3_next.l_hi = LOG_ROM[{1'b0, s2_reg.l_idx} + (TABLE_BITS+1)'(1)];
        znp          = (16+TLW)'(s2_reg.k) * (16+TLW)'(s2_reg.tl);
        s3_next.zn   = znp[12 +: ZW];
        zdp          = 47'(s2_reg.k) * 47'(LOG2E_Q30);
        s3_next.zd   = ZW'(zdp >> 12);
        s3_next.numv = DW'(s2_reg.bsel) << 12;
        s3_next.denv = (DW'(1) << (FRAC_BITS + 12)) + DW'(s2_reg.kp);
    end

    // S4: log interpolation, exp table reads
    always_comb
    begin
        logic [31+FRW:0] prod;
        s4_next       = s3_reg;
        prod          = (32+FRW)'(s3_reg.l_hi - s3_reg.l_lo) * (32+FRW)'(s3_reg.l_fr);
        s4_next.lg    = s3_reg.l_lo + 32'(prod >> FRW);
        s4_next.zi_n  = (s3_reg.zn[ZW-1:WB] > (ZW-WB)'(20)) ? 5'd20
                                                              : 5'(s3_reg.zn[ZW-1:WB]);
        s4_next.zi_d  = (s3_reg.zd[ZW-1:WB] > (ZW-WB)'(20)) ? 5'd20
                                                              : 5'(s3_reg.zd[ZW-1:WB]);
        s4_next.en_fr = s3_reg.zn[FRW-1:0];
        s4_next.ed_fr = s3_reg.zd[FRW-1:0];
        s4_next.en_lo = EXP_ROM[{1'b0, s3_reg.zn[WB-1 -: TABLE_BITS]}];
        s4_next.en_hi = EXP_ROM[{1'b0, s3_reg.zn[WB-1 -: TABLE_BITS]}
                                + (TABLE_BITS+1)'(1)];
        s4_next.ed_lo = EXP_ROM[{1'b0, s3_reg.zd[WB-1 -: TABLE_BITS]}];
        s4_next.ed_hi = EXP_ROM[{1'b0, s3_reg.zd[WB-1 -: TABLE_BITS]}
                                + (TABLE_BITS+1)'(1)];
    end

    // S5: -log2(b), exp interpolation
    always_comb
    begin
        logic [31+FRW:0] pn;
        logic [31+FRW:0] pd;
        s5_next      = s4_reg;
        s5_next.negq = ((NEGW'(FRAC_BITS) - NEGW'(s4_reg.p)) << WB) - NEGW'(s4_reg.lg);
        pn           = (32+FRW)'(s4_reg.en_hi - s4_reg.en_lo) * (32+FRW)'(s4_reg.en_fr);
        pd           = (32+FRW)'(s4_reg.ed_hi - s4_reg.ed_lo) * (32+FRW)'(s4_reg.ed_fr);
        s5_next.vn   = s4_reg.en_lo + 32'(pn >> FRW);
        s5_next.vd   = s4_reg.ed_lo + 32'(pd >> FRW);
    end

    // S6: scale log by exponent, build exponential quotient operands
    always_comb
    begin
        logic [NEGW+EW-1:0] yp;
        s6_next   = s5_reg;
        yp        = (NEGW+EW)'(s5_reg.negq) * (NEGW+EW)'(s5_reg.e);
        s6_next.y = yp[12 +: YW];
        if (s5_reg.mode == MODE_EXP)
        begin
            s6_next.numv = (DW'(s5_reg.vn) << s5_reg.zi_n) - (DW'(1) << WB);
            s6_next.denv = (DW'(s5_reg.vd) << s5_reg.zi_d) - (DW'(1) << WB);
        end
    end

    // S7: 2^-frac table read, final shift amount
    always_comb
    begin
        logic [WB:0]         g;
        logic [TABLE_BITS:0] gi;
        logic [10:0]         sh;
        s7_next = s6_reg;
        g       = (WB+1)'(1) << WB;
        g       = g - (WB+1)'(s6_reg.y[WB-1:0]);
        gi      = g[WB -: TABLE_BITS+1];
        if (gi[TABLE_BITS])
        begin
            s7_next.l_lo = EXP_ROM[TSIZE-1];
            s7_next.l_hi = EXP_ROM[TSIZE-1];
        end
        else
        begin
            s7_next.l_lo = EXP_ROM[gi];
            s7_next.l_hi = EXP_ROM[gi + (TABLE_BITS+1)'(1)];
        end
        s7_next.l_fr   = g[FRW-1:0];
        sh             = 11'(WB - FRAC_BITS + 1) + 11'(s6_reg.y[YW-1:WB]);
        s7_next.pw_big = (sh >= 11'd63);
        s7_next.pw_sh  = sh[5:0];
        s7_next.lin    = (s6_reg.k == '0) || (s6_reg.denv == '0);
    end

    // S8: 2^-frac interpolation
    always_comb
    begin
        logic [31+FRW:0] prod;
        s8_next    = s7_reg;
        prod       = (32+FRW)'(s7_reg.l_hi - s7_reg.l_lo) * (32+FRW)'(s7_reg.l_fr);
        s8_next.lg = s7_reg.l_lo + 32'(prod >> FRW);
    end

    // S9: power result, route to divider or bypass
    always_comb
    begin
        logic [31:0]      psh;
        logic [ONE_W-1:0] pw;
        psh = s8_reg.lg >> s8_reg.pw_sh;
        if (s8_reg.pw_zero)
            pw = '0;
        else if (s8_reg.pw_full)
            pw = ONE_W'(ONE);
        else if (s8_reg.pw_big)
            pw = '0;
        else
            pw = ONE_W'(psh);
        d_in_next.num     = s8_reg.numv;
        d_in_next.den     = s8_reg.denv;
        d_in_next.neg     = s8_reg.neg;
        d_in_next.inv     = !s8_reg.cneg;
        d_in_next.use_div = 1'b0;
        d_in_next.res     = s8_reg.a;
        case (s8_reg.mode)
            MODE_POWER:
            begin
                d_in_next.res = s8_reg.cneg ? pw : ONE_W'(ONE) - pw;
            end
            MODE_EXP:
            begin
                d_in_next.use_div = !s8_reg.lin;
            end
            MODE_POLY:
            begin
                d_in_next.use_div = 1'b1;
            end
            default:
            begin
                d_in_next.res = s8_reg.a;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) s1_reg   <= s1_next;
        if (rdy[1]) s2_reg   <= s2_next;
        if (rdy[2]) s3_reg   <= s3_next;
        if (rdy[3]) s4_reg   <= s4_next;
        if (rdy[4]) s5_reg   <= s5_next;
        if (rdy[5]) s6_reg   <= s6_next;
        if (rdy[6]) s7_reg   <= s7_next;
        if (rdy[7]) s8_reg   <= s8_next;
        if (rdy[8]) d_in_reg <= d_in_next;
        if (rdy[NS-1]) out_reg <= out_next;
    end

    trc_div u_div (
        .clk   (clk),
        .en    (rdy[NF+FRAC_BITS:NF]),
        .d_in  (d_in_reg),
        .d_out (d_out)
    );

    // output: complement and sign
    always_comb
    begin
        logic [ONE_W-1:0] q;
        logic [ONE_W-1:0] r;
        q = d_out.sat ? ONE_W'(ONE) : d_out.q;
        if (d_out.use_div)
            r = d_out.inv ? ONE_W'(ONE) - q : q;
        else
            r = d_out.res;
        out_next = d_out.neg ? (16'sd0 - signed'(16'(r))) : signed'(16'(r));
    end

endmodule
